// ===== src/flnl_pkg.sv =====
// ----------------------------------------------------------------------------
// flnl_pkg
// Shared types and constants for the fixed-point natural log pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package flnl_pkg;

  localparam int OUT_FRAC_BITS = 24;
  localparam int SHIFT_OUT     = 32 - OUT_FRAC_BITS;
  localparam int MAN_W         = 23;
  localparam int EXP_W         = 8;
  localparam int SUM_W         = 42;

  localparam logic [EXP_W-1:0] EXP_BIAS = 8'd127;
  localparam logic [EXP_W-1:0] EXP_ONES = 8'hFF;

  // ln2 in Q0.32, rounded to nearest
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
  // reciprocals for exact floor division of 32-bit values
  localparam logic [31:0] RECIP3  = 32'hAAAAAAAB;  // >> 33
  localparam logic [31:0] RECIP5  = 32'hCCCCCCCD;  // >> 34

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_ZERO    = 2'd1,
    STATUS_NEG     = 2'd2,
    STATUS_SPECIAL = 2'd3
  } status_t;

  typedef struct packed {
    logic                    valid;
    status_t                 status;
    logic signed [EXP_W:0]   ex;
    logic [MAN_W-1:0]        man;
  } tag_t;

  typedef struct packed {
    tag_t                    tag;
    logic [31:0]             y2;
    logic [31:0]             y4;
    logic [31:0]             y3d3;
    logic [31:0]             y5;
    logic signed [SUM_W-1:0] eln2;
  } pow_t;

endpackage

`default_nettype wire

// ===== src/flnl_powers.sv =====
// ----------------------------------------------------------------------------
// flnl_powers
// Three register stages forming y^2..y^5, y^3/3 and e*ln2.
// ----------------------------------------------------------------------------
`default_nettype none

module flnl_powers (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire flnl_pkg::tag_t tag_in,
  output flnl_pkg::pow_t     pow_out
);
  import flnl_pkg::*;

  // stage 1
  tag_t                    t1;
  logic [31:0]             y2_1;
  logic signed [SUM_W-1:0] eln2_1;
  logic [45:0]             p_sq;
  logic signed [SUM_W-1:0] p_ln;

  // stage 2
  tag_t                    t2;
  logic [31:0]             y2_2;
  logic [31:0]             y3_2;
  logic [31:0]             y4_2;
  logic signed [SUM_W-1:0] eln2_2;
  logic [54:0]             p_y3;
  logic [63:0]             p_y4;

  // stage 3
  logic [54:0]             p_y5;
  logic [63:0]             p_d3;

  assign p_sq = 46'(tag_in.man) * 46'(tag_in.man);
  assign p_ln = SUM_W'(tag_in.ex) * SUM_W'($signed({1'b0, LN2_Q32}));

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
    end else begin
      t1.valid <= tag_in.valid;
    end
    t1.status <= tag_in.status;
    t1.ex     <= tag_in.ex;
    t1.man    <= tag_in.man;
    y2_1      <= p_sq[45:14];
    eln2_1    <= p_ln;
  end

  assign p_y3 = 55'(y2_1) * 55'(t1.man);
  assign p_y4 = 64'(y2_1) * 64'(y2_1);

  always_ff @(posedge clk) begin
    if (rst) begin
      t2.valid <= 1'b0;
    end else begin
      t2.valid <= t1.valid;
    end
    t2.status <= t1.status;
    t2.ex     <= t1.ex;
    t2.man    <= t1.man;
    y2_2      <= y2_1;
    y3_2      <= p_y3[54:23];
    y4_2      <= p_y4[63:32];
    eln2_2    <= eln2_1;
  end

  assign p_y5 = 55'(y4_2) * 55'(t2.man);
  assign p_d3 = 64'(y3_2) * 64'(RECIP3);

  always_ff @(posedge clk) begin
    if (rst) begin
      pow_out.tag.valid <= 1'b0;
    end else begin
      pow_out.tag.valid <= t2.valid;
    end
    pow_out.tag.status <= t2.status;
    pow_out.tag.ex     <= t2.ex;
    pow_out.tag.man    <= t2.man;
    pow_out.y2         <= y2_2;
    pow_out.y4         <= y4_2;
    pow_out.y3d3       <= 32'(p_d3[63:33]);
    pow_out.y5         <= p_y5[54:23];
    pow_out.eln2       <= eln2_2;
  end

endmodule

`default_nettype wire

// ===== src/flnl_accum.sv =====
// ----------------------------------------------------------------------------
// flnl_accum
// Two register stages: y^5/5 and partial sum, then final sum, rounding,
// saturation and flag masking into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module flnl_accum (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire flnl_pkg::pow_t pow_in,
  output logic                done,
  output logic signed [31:0]  log_value,
  output logic [1:0]          status
);
  import flnl_pkg::*;

  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (SHIFT_OUT - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX  = SUM_W'(32'sh7FFFFFFF);
  localparam logic signed [SUM_W-1:0] SAT_MIN  = -(SUM_W'(1) <<< 31);

  // stage 4
  logic                    v4;
  status_t                 st4;
  logic [29:0]             y5d5_4;
  logic signed [SUM_W-1:0] part_4;
  logic [63:0]             p_d5;
  logic signed [SUM_W-1:0] part_next;

  // stage 5
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] rnd;
  logic signed [31:0]      log_next;

  assign p_d5 = 64'(pow_in.y5) * 64'(RECIP5);

  assign part_next = pow_in.eln2
                   + SUM_W'({pow_in.tag.man, 9'b0})
                   - SUM_W'(pow_in.y2 >> 1)
                   + SUM_W'(pow_in.y3d3)
                   - SUM_W'(pow_in.y4 >> 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= pow_in.tag.valid;
    end
    st4    <= pow_in.tag.status;
    y5d5_4 <= p_d5[63:34];
    part_4 <= part_next;
  end

  assign sum = part_4 + SUM_W'(y5d5_4);
  assign rnd = (sum + HALF_LSB) >>> SHIFT_OUT;

  always_comb begin
    if (st4 != STATUS_OK) begin
      log_next = '0;
    end else if (rnd > SAT_MAX) begin
      log_next = 32'sh7FFFFFFF;
    end else if (rnd < SAT_MIN) begin
      log_next = 32'sh80000000;
    end else begin
      log_next = rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4;
    end
    log_value <= log_next;
    status    <= st4;
  end

endmodule

`default_nettype wire

// ===== src/float_natural_log_approx.sv =====
// done follows the registers of stages 1 to 3, stage 4 and the output stage, in that order.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Stages 1-3 are two multipliers side by side; stage 4 one multiplier beside a wide add.
// Reset (rst, synchronous) clears the valid bits; transactions in flight are lost.
// Results are shown for one cycle only, the receiver cannot stall.
// ----------------------------------------------------------------------------
// float_natural_log_approx
// Natural log of a single-precision value as signed Q.24 fixed point, with
// flagging of zero/subnormal, negative and infinity/NaN inputs.
// ----------------------------------------------------------------------------
`default_nettype none

module float_natural_log_approx (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [31:0]  float_bits,
  output logic              done,
  output logic signed [31:0] log_value,
  output logic [1:0]        status
);
  import flnl_pkg::*;

  logic [EXP_W-1:0] exf;
  tag_t             tag_in;
  pow_t             pow;

  assign busy = 1'b0;
  assign exf  = float_bits[30:23];

  always_comb begin
    tag_in.valid = start && !busy;
    tag_in.man   = float_bits[MAN_W-1:0];
    tag_in.ex    = $signed({1'b0, exf}) - $signed({1'b0, EXP_BIAS});
    if (exf == EXP_ONES) begin
      tag_in.status = STATUS_SPECIAL;
    end else if (exf == '0) begin
      tag_in.status = STATUS_ZERO;
    end else if (float_bits[31]) begin
      tag_in.status = STATUS_NEG;
    end else begin
      tag_in.status = STATUS_OK;
    end
  end

  flnl_powers u_powers (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tag_in),
    .pow_out (pow)
  );

  flnl_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .pow_in    (pow),
    .done      (done),
    .log_value (log_value),
    .status    (status)
  );

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 5))
    else $error("result without a transaction five cycles earlier");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("transaction lost in the pipeline");

  a_flag_zeroes_value: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STATUS_OK)) |-> (log_value == '0))
    else $error("flagged result carries a non-zero value");

  a_flag_from_input: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_OK)) |-> ($past(float_bits[31], 5) == 1'b0))
    else $error("negative input reported as ok");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for float_natural_log_approx. A directed stimulus list
// covers the status flags and the edges of the exponent and mantissa, then
// random single-precision patterns follow, biased towards normal positive
// values. Each result is compared with a typed expectation or with a
// fixed-point predictor of the truncated series for ln(x).
// ----------------------------------------------------------------------------

module tb;
  import flnl_pkg::*;

  localparam int N_RANDOM = 1500;

  typedef struct {
    logic signed [31:0] log_value;
    status_t            status;
  } ln_result_t;

  typedef struct {
    logic [31:0]        bits;
    bit                 typed;
    logic signed [31:0] log_value;
    status_t            status;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [31:0]        float_bits = '0;
  logic               busy;
  logic               done;
  logic signed [31:0] log_value;
  logic [1:0]         status;

  ln_result_t pending_ln[$];
  ln_result_t drive_ln;
  ln_result_t oldest_ln;
  stim_row_t  stim_rows[$];
  int         errors = 0;

  float_natural_log_approx u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .float_bits (float_bits),
    .done       (done),
    .log_value  (log_value),
    .status     (status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic ln_result_t predict_ln(input logic [31:0] bits);
    ln_result_t  res;
    logic [7:0]  ex;
    logic [22:0] man;
    logic [63:0] yq, y2, y3, y4, y5;
    longint      poly, v, u, r;
    ex  = bits[30:23];
    man = bits[22:0];
    res.log_value = '0;
    if (ex == EXP_ONES) begin
      res.status = STATUS_SPECIAL;
    end else if (ex == 8'd0) begin
      res.status = STATUS_ZERO;
    end else if (bits[31]) begin
      res.status = STATUS_NEG;
    end else begin
      res.status = STATUS_OK;
      yq = {32'd0, man, 9'd0};
      y2 = (yq * yq) >> 32;
      y3 = (y2 * yq) >> 32;
      y4 = (y2 * y2) >> 32;
      y5 = (y4 * yq) >> 32;
      poly = longint'(yq) - longint'(y2 >> 1) + longint'(y3 / 64'd3)
           - longint'(y4 >> 2) + longint'(y5 / 64'd5);
      v = (longint'(ex) - 64'sd127) * longint'(LN2_Q32) + poly;
      // offset keeps the value positive so the shift floors
      u = v + (64'sd1 <<< 48);
      u = (u + (64'sd1 <<< (SHIFT_OUT - 1))) >>> SHIFT_OUT;
      r = u - ((64'sd1 <<< 48) >>> SHIFT_OUT);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      res.log_value = r[31:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] random_float();
    int          pick;
    logic [7:0]  ex;
    logic [22:0] man;
    logic        sgn;
    pick = $urandom_range(0, 99);
    sgn  = 1'b0;
    man  = 23'($urandom);
    if (pick < 50) begin
      ex = 8'($urandom_range(1, 254));
    end else if (pick < 62) begin
      case ($urandom_range(0, 6))
        0: ex = 8'd1;
        1: ex = 8'd2;
        2: ex = 8'd126;
        3: ex = 8'd127;
        4: ex = 8'd128;
        5: ex = 8'd253;
        default: ex = 8'd254;
      endcase
      case ($urandom_range(0, 3))
        0: man = '0;
        1: man = 23'h7FFFFF;
        default: ;
      endcase
    end else if (pick < 72) begin
      ex  = 8'($urandom_range(126, 127));
      man = $urandom_range(0, 1) ? man >> $urandom_range(0, 22)
                                 : ~(man >> $urandom_range(0, 22));
    end else if (pick < 82) begin
      ex  = $urandom_range(0, 1) ? 8'd0 : EXP_ONES;
      sgn = 1'($urandom_range(0, 1));
    end else begin
      return $urandom;
    end
    return {sgn, ex, man};
  endfunction

  task automatic stim_row(input logic [31:0] bits, input bit typed,
                          input logic signed [31:0] lv, input status_t st);
    stim_row_t row;
    row.bits      = bits;
    row.typed     = typed;
    row.log_value = lv;
    row.status    = st;
    stim_rows.push_back(row);
  endtask

  task automatic send_transaction(input logic [31:0] bits, input ln_result_t exp_res,
                                  input int gap);
    repeat (gap) begin
      @(negedge clk);
      start      <= 1'b0;
      float_bits <= $urandom;
    end
    @(negedge clk);
    start      <= 1'b1;
    float_bits <= bits;
    drive_ln   = exp_res;
    do @(posedge clk); while (busy);
  endtask

  // result checking and capture of accepted transactions
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_ln.size() == 0) begin
          $display("%0t: unexpected result log_value=%h status=%0d",
                   $time, log_value, status);
          errors++;
        end else begin
          oldest_ln = pending_ln.pop_front();
          if (log_value !== oldest_ln.log_value) begin
            $display("%0t: log_value mismatch expected %h actual %h",
                     $time, oldest_ln.log_value, log_value);
            errors++;
          end
          if (status !== oldest_ln.status) begin
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, oldest_ln.status, status);
            errors++;
          end
        end
      end
      if (start && !busy) pending_ln.push_back(drive_ln);
    end
  end

  initial begin
    ln_result_t exp_res;
    logic [31:0] bits;
    int          idle_max;
    int          drain;

    stim_row(32'h3F800000, 1'b1, 32'sd0, STATUS_OK);
    stim_row(32'h00000000, 1'b1, 32'sd0, STATUS_ZERO);
    stim_row(32'h80000000, 1'b1, 32'sd0, STATUS_ZERO);
    stim_row(32'h00000001, 1'b1, 32'sd0, STATUS_ZERO);
    stim_row(32'h807FFFFF, 1'b1, 32'sd0, STATUS_ZERO);
    stim_row(32'h7F800000, 1'b1, 32'sd0, STATUS_SPECIAL);
    stim_row(32'hFF800000, 1'b1, 32'sd0, STATUS_SPECIAL);
    stim_row(32'h7FC00000, 1'b1, 32'sd0, STATUS_SPECIAL);
    stim_row(32'h7F800001, 1'b1, 32'sd0, STATUS_SPECIAL);
    stim_row(32'hFFFFFFFF, 1'b1, 32'sd0, STATUS_SPECIAL);
    stim_row(32'hBF800000, 1'b1, 32'sd0, STATUS_NEG);
    stim_row(32'h80800000, 1'b1, 32'sd0, STATUS_NEG);
    stim_row(32'hFF7FFFFF, 1'b1, 32'sd0, STATUS_NEG);
    stim_row(32'h00800000, 1'b0, 32'sd0, STATUS_OK);
    stim_row(32'h00FFFFFF, 1'b0, 32'sd0, STATUS_OK);
    stim_row(32'h7F7FFFFF, 1'b0, 32'sd0, STATUS_OK);
    stim_row(32'h7F000000, 1'b0, 32'sd0, STATUS_OK);
    stim_row(32'h3F7FFFFF, 1'b0, 32'sd0, STATUS_OK);
    stim_row(32'h3F800001, 1'b0, 32'sd0, STATUS_OK);
    stim_row(32'h3FFFFFFF, 1'b0, 32'sd0, STATUS_OK);
    stim_row(32'h40000000, 1'b0, 32'sd0, STATUS_OK);
    stim_row(32'h3FC00000, 1'b0, 32'sd0, STATUS_OK);
    stim_row(32'h402DF854, 1'b0, 32'sd0, STATUS_OK);
    stim_row(32'h55555555, 1'b0, 32'sd0, STATUS_OK);
    stim_row(32'h2AAAAAAA, 1'b0, 32'sd0, STATUS_OK);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].typed) begin
        exp_res.log_value = stim_rows[i].log_value;
        exp_res.status    = stim_rows[i].status;
      end else begin
        exp_res = predict_ln(stim_rows[i].bits);
      end
      send_transaction(stim_rows[i].bits, exp_res, $urandom_range(0, 2));
    end

    idle_max = 8;
    for (int n = 0; n < N_RANDOM; n++) begin
      // back-to-back bursts between stretches of random gaps
      if (n % 64 == 0) idle_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      bits = random_float();
      send_transaction(bits, predict_ln(bits), $urandom_range(0, idle_max));
    end
    @(negedge clk);
    start <= 1'b0;

    drain = 0;
    while (pending_ln.size() != 0 && drain < 200) begin
      @(posedge clk);
      drain++;
    end
    repeat (12) @(posedge clk);
    if (pending_ln.size() != 0)
      $display("%0t: %0d results never arrived", $time, pending_ln.size());
    if (errors == 0 && pending_ln.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
